// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/pc_pkg.sv =====
// ----------------------------------------------------------------------------
// pc_pkg
// Types, widths and codes for the streaming correlation block.
// ----------------------------------------------------------------------------
package pc_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = 13;
  localparam int SX_W        = 28;   // signed sum of samples
  localparam int SXX_W       = 43;   // unsigned sum of squares
  localparam int SXY_W       = 44;   // signed sum of cross products
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int V_W         = 56;   // variance terms
  localparam int CV_W        = 58;   // signed covariance term
  localparam int MAG_W       = 57;
  localparam int AB_W        = 112;
  localparam int RHS_W       = 146;
  localparam int MA_W        = 64;   // serial multiplier operand
  localparam int MB_W        = 128;  // parallel multiplicand
  localparam int P_W         = MA_W + MB_W;
  localparam int MCNT_W      = 6;
  localparam int M_W         = 16;
  localparam int BIT_W       = 4;
  localparam int T_W         = M_W + 1;
  localparam int T2_W        = 2 * T_W;
  localparam int STAT_W      = 2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;

  typedef enum logic [3:0] {
    OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NSXY, OP_SXSY, OP_AB, OP_CC, OP_CAND
  } op_t;

  typedef enum logic [2:0] {
    S_ACC, S_FLUSH, S_START, S_MUL, S_ADV, S_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic mul_start;
    logic store;
    logic cand_init;
    logic cand_next;
    logic emit;
    op_t  op;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic ovf;
    logic ab_zero;
    logic bit_zero;
    logic mul_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/pearson_correlation_top.sv =====
// ----------------------------------------------------------------------------
// pearson_correlation_top
// Streaming Pearson correlation of signed sample pairs, Q1.15 result.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per sample pair, x in tdata[15:0], y in tdata[31:16],
//           in_tlast marks the final pair of a set.
//   out_* : one beat per set: correlation, status and pair count.
//   While a set is being gathered a pair is taken every cycle.
//   After the last pair in_tready drops while the final arithmetic runs on
//   one shared shift-and-add multiplier (64 steps per product):
//     normal set        : 24 products;
//     zero variance     : 8 products;
//     too many samples  : no products.
//   The result waits in an output register. If the receiver stalls, pairs
//   of the following set are still accepted up to its last pair; its result
//   is then held and in_tready stays low until the register is free.
//   Reset (rst_n low, synchronous) clears all sums, the count and the
//   output valid.
// ----------------------------------------------------------------------------
module pearson_correlation_top
  import pc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_sample[15:0], y_sample[31:16]
  input  logic        in_tlast,   // last_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // correlation[15:0], status[17:16],
                                  // pair_count[30:18], zero[31]
);

  ctl_cmd_t          cmd;
  dp_status_t        st;
  logic              in_accept;
  logic [M_W-1:0]    corr;
  logic [STAT_W-1:0] stat;
  logic [CNT_W-1:0]  cnt;

  assign in_tready = cmd.in_ready;
  assign in_accept = in_tvalid && cmd.in_ready;

  pc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_last   (in_tlast),
    .st        (st),
    .cmd       (cmd)
  );

  pc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .x_sample    (in_tdata[SAMPLE_W-1:0]),
    .y_sample    (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .cmd         (cmd),
    .status      (st),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .correlation (corr),
    .res_status  (stat),
    .pair_count  (cnt)
  );

  assign out_tdata = {1'b0, cnt, stat, corr};

endmodule

// ===== hw/rtl/pc_mul.sv =====
// ----------------------------------------------------------------------------
// pc_mul
// Shift-and-add unsigned multiplier, one operand bit per cycle.
// ----------------------------------------------------------------------------
module pc_mul
  import pc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [MA_W-1:0] a,
  input  logic [MB_W-1:0] b,
  output logic            done,
  output logic [P_W-1:0]  product
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [P_W-1:0]    p_r, p_nxt;
  logic [MB_W-1:0]   b_r, b_nxt;
  logic [MB_W:0]     sum;

  assign sum = {1'b0, p_r[P_W-1:MA_W]} + (p_r[0] ? {1'b0, b_r} : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      p_nxt    = {{MB_W{1'b0}}, a};
      b_nxt    = b;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[MA_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {MCNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    p_r <= p_nxt;
    b_r <= b_nxt;
  end

  assign done    = done_r;
  assign product = p_r;

`include "assert_macros.svh"
  `ASSERT_NEVER(a_start_while_busy, start && busy_r, "multiply started while busy")

endmodule

// ===== hw/rtl/pc_dp.sv =====
// ----------------------------------------------------------------------------
// pc_dp
// Accumulators, final arithmetic registers and the result register.
// ----------------------------------------------------------------------------
module pc_dp
  import pc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [SAMPLE_W-1:0] x_sample,
  input  logic [SAMPLE_W-1:0] y_sample,
  input  ctl_cmd_t            cmd,
  output dp_status_t          status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [M_W-1:0]      correlation,
  output logic [STAT_W-1:0]   res_status,
  output logic [CNT_W-1:0]    pair_count
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
  localparam logic [M_W-1:0]   Q_ONE   = {1'b1, {(M_W-1){1'b0}}};
  localparam logic [M_W-1:0]   Q_MAX   = {1'b0, {(M_W-1){1'b1}}};

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [SAMPLE_W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic                v1_r, v2_r;
  logic [PROD_W-1:0]   xx2_r, yy2_r, xy2_r;
  logic [SX_W-1:0]     sx_r, sy_r;
  logic [SXX_W-1:0]    sxx_r, syy_r;
  logic [SXY_W-1:0]    sxy_r;

  logic [CV_W-1:0]     tmp_r, cv_r;
  logic [V_W-1:0]      va_r, vb_r;
  logic [AB_W-1:0]     ab_r;
  logic [RHS_W-1:0]    rhs_r;
  logic [M_W-1:0]      m_r;
  logic [BIT_W-1:0]    bit_r;

  logic                out_valid_r;
  logic [M_W-1:0]      out_corr_r;
  logic [STAT_W-1:0]   out_stat_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic [SX_W-1:0]     sx_mag, sy_mag;
  logic [SXY_W-1:0]    sxy_mag;
  logic [MAG_W-1:0]    cv_mag;
  logic [CV_W-1:0]     p_low, p_neg, cv_all;
  logic [M_W-1:0]      cand;
  logic                cand_ok;
  logic [T_W-1:0]      t;
  logic [T2_W-1:0]     t2;
  logic [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic                mul_done;
  logic [P_W-1:0]      mul_p;
  logic [M_W-1:0]      corr_val;
  logic [STAT_W-1:0]   stat_val;

  // ---- accumulation: count, products, sums -------------------------------
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.emit) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (in_accept) begin
      if (count_r == CNT_MAX) ovf_nxt = 1'b1;
      else                    count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      syy_r   <= '0;
      sxy_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      v1_r    <= in_accept && (count_r != CNT_MAX);
      v2_r    <= v1_r;
      if (cmd.emit) begin
        sx_r  <= '0;
        sy_r  <= '0;
        sxx_r <= '0;
        syy_r <= '0;
        sxy_r <= '0;
      end else if (v2_r) begin
        sx_r  <= sx_r + {{(SX_W-SAMPLE_W){x2_r[SAMPLE_W-1]}}, x2_r};
        sy_r  <= sy_r + {{(SX_W-SAMPLE_W){y2_r[SAMPLE_W-1]}}, y2_r};
        sxx_r <= sxx_r + {{(SXX_W-PROD_W){1'b0}}, xx2_r};
        syy_r <= syy_r + {{(SXX_W-PROD_W){1'b0}}, yy2_r};
        sxy_r <= sxy_r + {{(SXY_W-PROD_W){xy2_r[PROD_W-1]}}, xy2_r};
      end
    end
    if (in_accept) begin
      x1_r <= x_sample;
      y1_r <= y_sample;
    end
    x2_r  <= x1_r;
    y2_r  <= y1_r;
    xx2_r <= PROD_W'($signed(x1_r) * $signed(x1_r));
    yy2_r <= PROD_W'($signed(y1_r) * $signed(y1_r));
    xy2_r <= PROD_W'($signed(x1_r) * $signed(y1_r));
  end

  // ---- final arithmetic ---------------------------------------------------
  assign sx_mag  = sx_r[SX_W-1] ? (~sx_r + 1'b1) : sx_r;
  assign sy_mag  = sy_r[SX_W-1] ? (~sy_r + 1'b1) : sy_r;
  assign sxy_mag = sxy_r[SXY_W-1] ? (~sxy_r + 1'b1) : sxy_r;
  assign cv_all  = cv_r[CV_W-1] ? (~cv_r + 1'b1) : cv_r;
  assign cv_mag  = cv_all[MAG_W-1:0];
  assign p_low   = mul_p[CV_W-1:0];
  assign p_neg   = ~p_low + 1'b1;

  assign cand    = m_r | (M_W'(1) << bit_r);
  assign cand_ok = (cand <= Q_ONE);
  assign t       = {cand, 1'b0} - 1'b1;
  assign t2      = t * t;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_NSXX: begin mul_a = MA_W'(count_r); mul_b = MB_W'(sxx_r);   end
      OP_SXSX: begin mul_a = MA_W'(sx_mag);  mul_b = MB_W'(sx_mag);  end
      OP_NSYY: begin mul_a = MA_W'(count_r); mul_b = MB_W'(syy_r);   end
      OP_SYSY: begin mul_a = MA_W'(sy_mag);  mul_b = MB_W'(sy_mag);  end
      OP_NSXY: begin mul_a = MA_W'(count_r); mul_b = MB_W'(sxy_mag); end
      OP_SXSY: begin mul_a = MA_W'(sx_mag);  mul_b = MB_W'(sy_mag);  end
      OP_AB:   begin mul_a = MA_W'(va_r);    mul_b = MB_W'(vb_r);    end
      OP_CC:   begin mul_a = MA_W'(cv_mag);  mul_b = MB_W'(cv_mag);  end
      OP_CAND: begin mul_a = MA_W'(t2);      mul_b = MB_W'(ab_r);    end
      default: begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  pc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        OP_NSXX: tmp_r <= p_low;
        OP_SXSX: va_r  <= tmp_r[V_W-1:0] - mul_p[V_W-1:0];
        OP_NSYY: tmp_r <= p_low;
        OP_SYSY: vb_r  <= tmp_r[V_W-1:0] - mul_p[V_W-1:0];
        OP_NSXY: tmp_r <= sxy_r[SXY_W-1] ? p_neg : p_low;
        OP_SXSY: cv_r  <= tmp_r - ((sx_r[SX_W-1] ^ sy_r[SX_W-1]) ? p_neg : p_low);
        OP_AB:   ab_r  <= mul_p[AB_W-1:0];
        OP_CC:   rhs_r <= {mul_p[RHS_W-33:0], 32'b0};
        OP_CAND: if (cand_ok && (mul_p <= P_W'(rhs_r))) m_r <= cand;
        default: ;
      endcase
    end
    if (cmd.cand_init) begin
      m_r   <= '0;
      bit_r <= BIT_W'(M_W - 1);
    end else if (cmd.cand_next) begin
      bit_r <= bit_r - 1'b1;
    end
  end

  // ---- result register ----------------------------------------------------
  always_comb begin
    corr_val = '0;
    stat_val = ST_OK;
    if (ovf_r) begin
      stat_val = ST_OVF;
    end else if (ab_r == '0) begin
      stat_val = ST_ZERO;
    end else if (cv_r[CV_W-1]) begin
      corr_val = ~m_r + 1'b1;
    end else begin
      corr_val = m_r[M_W-1] ? Q_MAX : m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_corr_r <= corr_val;
      out_stat_r <= stat_val;
      out_cnt_r  <= count_r;
    end
  end

  assign status.pipe_busy = v1_r | v2_r;
  assign status.ovf       = ovf_r;
  assign status.ab_zero   = (ab_r == '0);
  assign status.bit_zero  = (bit_r == '0);
  assign status.mul_done  = mul_done;
  assign status.out_busy  = out_valid_r;

  assign out_valid   = out_valid_r;
  assign correlation = out_corr_r;
  assign res_status  = out_stat_r;
  assign pair_count  = out_cnt_r;

`include "assert_macros.svh"
  `ASSERT_CLK(a_count_bound, count_r <= CNT_MAX, "pair count beyond limit")

endmodule

// ===== hw/rtl/pc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pc_ctrl
// Sequencer: accumulate, flush, step through the multiply chain, emit.
// ----------------------------------------------------------------------------
module pc_ctrl
  import pc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic       in_last,
  input  dp_status_t st,
  output ctl_cmd_t   cmd
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_ACC:   if (in_accept && in_last) state_nxt = S_FLUSH;
      S_FLUSH: begin
        if (!st.pipe_busy) begin
          if (st.ovf) begin
            state_nxt = S_DONE;
          end else begin
            op_nxt    = OP_NSXX;
            state_nxt = S_START;
          end
        end
      end
      S_START: state_nxt = S_MUL;
      S_MUL:   if (st.mul_done) state_nxt = S_ADV;
      S_ADV: begin
        state_nxt = S_START;
        case (op_r)
          OP_NSXX: op_nxt = OP_SXSX;
          OP_SXSX: op_nxt = OP_NSYY;
          OP_NSYY: op_nxt = OP_SYSY;
          OP_SYSY: op_nxt = OP_NSXY;
          OP_NSXY: op_nxt = OP_SXSY;
          OP_SXSY: op_nxt = OP_AB;
          OP_AB:   op_nxt = OP_CC;
          OP_CC: begin
            if (st.ab_zero) state_nxt = S_DONE;
            else            op_nxt    = OP_CAND;
          end
          OP_CAND: if (st.bit_zero) state_nxt = S_DONE;
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE:  if (!st.out_busy) state_nxt = S_ACC;
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      S_ACC:   cmd.in_ready  = 1'b1;
      S_START: cmd.mul_start = 1'b1;
      S_MUL:   cmd.store     = st.mul_done;
      S_ADV: begin
        cmd.cand_init = (op_r == OP_CC) && !st.ab_zero;
        cmd.cand_next = (op_r == OP_CAND) && !st.bit_zero;
      end
      S_DONE:  cmd.emit      = !st.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      op_r    <= OP_NSXX;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_done_in_mul, st.mul_done |-> (state_r == S_MUL), "multiply done out of step")
  `ASSERT_CLK(a_no_accept_busy, (state_r != S_ACC) |-> !in_accept, "beat taken while busy")

endmodule
